@@ hw/rtl/gzip_header_parser_defines.svh @@
// ----------------------------------------------------------------------------
// gzip header parser assertion macros
// check forms used by the header parser rtl, gzip_header_parser.sv
// ----------------------------------------------------------------------------
`ifndef GZIP_HEADER_PARSER_DEFINES_SVH
`define GZIP_HEADER_PARSER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define GZHP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define GZHP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/gzhp_pkg.sv @@
// ----------------------------------------------------------------------------
// gzhp_pkg
// types, codes and helpers for the gzip member header parser
// ----------------------------------------------------------------------------
`default_nettype none

package gzhp_pkg;

  // parse phases, all eight codes are in use
  typedef enum logic [2:0] {
    PH_FIXED     = 3'd0,
    PH_EXTRA_LEN = 3'd1,
    PH_EXTRA     = 3'd2,
    PH_NAME      = 3'd3,
    PH_COMMENT   = 3'd4,
    PH_HCRC      = 3'd5,
    PH_RUN       = 3'd6,
    PH_ERROR     = 3'd7
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_HEADER  = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_NOTGZ   = 3'd2,
    ST_METHOD  = 3'd3,
    ST_RESTART = 3'd4
  } status_t;

  // command codes
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // header constants
  localparam logic [7:0]  MAGIC0      = 8'h1f;
  localparam logic [7:0]  MAGIC1      = 8'h8b;
  localparam logic [7:0]  METHOD_DEFL = 8'd8;
  localparam int unsigned FIXED_LEN   = 10;
  localparam logic [15:0] FIXED_LAST  = 16'(FIXED_LEN - 1);

  // byte positions inside the fixed header
  localparam logic [15:0] POS_MAGIC0 = 16'd0;
  localparam logic [15:0] POS_MAGIC1 = 16'd1;
  localparam logic [15:0] POS_METHOD = 16'd2;
  localparam logic [15:0] POS_FLAGS  = 16'd3;

  // flag bits
  localparam logic [7:0] FL_HCRC    = 8'(1 << 1);
  localparam logic [7:0] FL_EXTRA   = 8'(1 << 2);
  localparam logic [7:0] FL_NAME    = 8'(1 << 3);
  localparam logic [7:0] FL_COMMENT = 8'(1 << 4);

  // first optional field still to come, searching from phase 'from'
  function automatic phase_t next_phase(input logic [7:0] flags, input phase_t from);
    phase_t ph;
    ph = PH_RUN;
    if (from <= PH_HCRC && (flags & FL_HCRC) != 8'd0) ph = PH_HCRC;
    if (from <= PH_COMMENT && (flags & FL_COMMENT) != 8'd0) ph = PH_COMMENT;
    if (from <= PH_NAME && (flags & FL_NAME) != 8'd0) ph = PH_NAME;
    if (from <= PH_EXTRA_LEN && (flags & FL_EXTRA) != 8'd0) ph = PH_EXTRA_LEN;
    return ph;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gzip_header_parser.sv @@
// ----------------------------------------------------------------------------
// gzip_header_parser
// strips the gzip member header from a byte stream and passes the
// compressed payload bytes on, reporting bad magic or method
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | command, data_byte, stream_end
//  out     | out_valid/out_stall| status, payload_valid, payload_byte,
//          |                    | payload_last
//
// one item per cycle sustained while out_stall stays low; an item passes the
// input register, then the result register, with the parse state updated
// as it enters the result register.
// rst is synchronous and clears both stages and the parse state.
// a stalled result holds the result register; the input register then holds
// too and in_stall rises once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gzip_header_parser_defines.svh"

module gzip_header_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       command,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      status,
  output logic            payload_valid,
  output logic [7:0]      payload_byte,
  output logic            payload_last
);

  import gzhp_pkg::*;

  // input register
  logic       s1_valid;
  logic       s1_command;
  logic [7:0] s1_data;
  logic       s1_end;

  // parse state
  phase_t      phase;
  logic [15:0] byte_count;
  logic [7:0]  header_flags;
  logic [15:0] extra_length;
  logic        magic_bad;
  logic        method_bad;

  phase_t      phase_next;
  logic [15:0] byte_count_next;
  logic [7:0]  header_flags_next;
  logic [15:0] extra_length_next;
  logic        magic_bad_next;
  logic        method_bad_next;

  // result of the item in the input register
  status_t     res_status;
  logic        res_valid;
  logic [7:0]  res_byte;

  logic        adv;
  logic [15:0] count_inc;
  logic [15:0] extra_len_full;

  // pipeline moves whenever the result register is free or being taken
  assign adv      = !(out_valid && out_stall);
  assign in_stall = s1_valid && !adv;

  assign count_inc      = byte_count + 16'd1;
  assign extra_len_full = {s1_data, extra_length[7:0]};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_command <= command;
      s1_data    <= data_byte;
      s1_end     <= stream_end;
    end
  end

  // next parse state
  always_comb begin
    phase_next        = phase;
    byte_count_next   = byte_count;
    header_flags_next = header_flags;
    extra_length_next = extra_length;
    magic_bad_next    = magic_bad;
    method_bad_next   = method_bad;
    if (s1_command == CMD_RESTART) begin
      phase_next        = PH_FIXED;
      byte_count_next   = 16'd0;
      header_flags_next = 8'd0;
      extra_length_next = 16'd0;
      magic_bad_next    = 1'b0;
      method_bad_next   = 1'b0;
    end else begin
      unique case (phase)
        PH_FIXED: begin
          if (byte_count == POS_MAGIC0 && s1_data != MAGIC0) magic_bad_next = 1'b1;
          if (byte_count == POS_MAGIC1 && s1_data != MAGIC1) magic_bad_next = 1'b1;
          if (byte_count == POS_METHOD && s1_data != METHOD_DEFL) method_bad_next = 1'b1;
          if (byte_count == POS_FLAGS) header_flags_next = s1_data;
          if (byte_count >= FIXED_LAST) begin
            byte_count_next = 16'd0;
            if (magic_bad || method_bad) begin
              phase_next = PH_ERROR;
            end else begin
              phase_next = next_phase(header_flags, PH_EXTRA_LEN);
            end
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_EXTRA_LEN: begin
          if (byte_count == 16'd0) begin
            extra_length_next = {8'd0, s1_data};
            byte_count_next   = 16'd1;
          end else begin
            extra_length_next = extra_len_full;
            byte_count_next   = 16'd0;
            if (extra_len_full == 16'd0) begin
              phase_next = next_phase(header_flags, PH_NAME);
            end else begin
              phase_next = PH_EXTRA;
            end
          end
        end
        PH_EXTRA: begin
          if (count_inc >= extra_length) begin
            byte_count_next = 16'd0;
            phase_next      = next_phase(header_flags, PH_NAME);
          end else begin
            byte_count_next = count_inc;
          end
        end
        PH_NAME: begin
          if (s1_data == 8'd0) phase_next = next_phase(header_flags, PH_COMMENT);
        end
        PH_COMMENT: begin
          if (s1_data == 8'd0) phase_next = next_phase(header_flags, PH_HCRC);
        end
        PH_HCRC: begin
          if (byte_count == 16'd0) begin
            byte_count_next = 16'd1;
          end else begin
            byte_count_next = 16'd0;
            phase_next      = PH_RUN;
          end
        end
        PH_RUN: begin
          phase_next = PH_RUN;
        end
        PH_ERROR: begin
          phase_next = PH_ERROR;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    res_status = ST_HEADER;
    res_valid  = 1'b0;
    res_byte   = 8'd0;
    if (s1_command == CMD_RESTART) begin
      res_status = ST_RESTART;
    end else begin
      unique case (phase)
        PH_FIXED: begin
          if (byte_count >= FIXED_LAST) begin
            if (magic_bad) begin
              res_status = ST_NOTGZ;
            end else if (method_bad) begin
              res_status = ST_METHOD;
            end
          end
        end
        PH_RUN: begin
          res_status = ST_PAYLOAD;
          res_valid  = 1'b1;
          res_byte   = s1_data;
        end
        PH_ERROR: begin
          res_status = magic_bad ? ST_NOTGZ : ST_METHOD;
        end
        PH_EXTRA_LEN, PH_EXTRA, PH_NAME, PH_COMMENT, PH_HCRC: begin
          res_status = ST_HEADER;
        end
      endcase
    end
  end

  // parse state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      phase        <= PH_FIXED;
      byte_count   <= 16'd0;
      header_flags <= 8'd0;
      extra_length <= 16'd0;
      magic_bad    <= 1'b0;
      method_bad   <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        phase        <= phase_next;
        byte_count   <= byte_count_next;
        header_flags <= header_flags_next;
        extra_length <= extra_length_next;
        magic_bad    <= magic_bad_next;
        method_bad   <= method_bad_next;
      end
    end
    if (adv && s1_valid) begin
      status        <= res_status;
      payload_valid <= res_valid;
      payload_byte  <= res_byte;
      payload_last  <= s1_end;
    end
  end

  // checks
  `GZHP_ASSERT_NOW(a_payload_status, clk, rst, out_valid && payload_valid, status == ST_PAYLOAD, "payload item without payload status")
  `GZHP_ASSERT_NOW(a_error_cause, clk, rst, phase == PH_ERROR, magic_bad || method_bad, "error phase without a latched cause")
  `GZHP_ASSERT_NOW(a_fixed_count, clk, rst, phase == PH_FIXED, byte_count <= FIXED_LAST, "fixed header count out of range")
  `GZHP_ASSERT_NOW(a_full_stall, clk, rst, s1_valid && out_valid && out_stall, in_stall, "input taken while both stages are held")
  `GZHP_ASSERT_NEXT(a_restart_clear, clk, rst, adv && s1_valid && s1_command == CMD_RESTART, phase == PH_FIXED && byte_count == 16'd0 && !magic_bad && !method_bad, "restart did not clear the parse state")

endmodule

`default_nettype wire
